// File: hdl/epml_pkg.sv
// Package for the Euclidean Prim spanning tree length core.
// Holds the item structs, sizes and constants; depends on nothing.
package epml_pkg;
    localparam int MAX_POINTS = 256;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int LEN_W      = 48;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
    localparam logic [32:0] KQ = 33'd7287613858;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic [LEN_W-1:0] tree_length;
        logic [8:0]       point_count;
        logic             saturated;
    } result_t;
endpackage

// File: hdl/euclidean_prim_mst_length_core.sv
// Top level of the Euclidean Prim spanning tree length core.
// Depends on epml_pkg, epml_ram and epml_sqrt_cell.
//
// Usage: points are transferred on start/busy, one per cycle while loading.
// The point with last_point set closes the set; busy then rises while a
// dense Prim run from point 0 evaluates edges. Each edge streams through a
// chain of 33 square root cells (one root bit per cell) and two multiply
// stages. A set of one point goes straight to the result strobe.
// When the run ends, result_valid is high for one cycle with tree_length,
// point_count and saturated, and busy falls. The receiver cannot stall.
// Reset clears the control state, the point count and the total; the
// point memories are not cleared and need none. Points beyond 256 are
// dropped, but a dropped last point still closes the set.
module euclidean_prim_mst_length_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  epml_pkg::point_t  point,
    output logic              result_valid,
    output epml_pkg::result_t result
);
    localparam int IW = epml_pkg::IDX_W;
    localparam int CW = epml_pkg::CNT_W;
    localparam int LW = epml_pkg::LEN_W;
    localparam int NC = 33;

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_DRAIN, S_DONE} state_t;

    state_t         state_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  scan_reg;
    logic [CW-1:0]  round_reg;
    logic [LW-1:0]  total_reg;
    logic           sat_reg;
    logic [LW-1:0]  min_reg;
    logic [IW-1:0]  pick_reg;
    logic           found_reg;
    logic [31:0]    cx_reg, cy_reg;

    logic           accept;
    logic [31:0]    xr, yr;
    logic [LW:0]    br;
    logic           we_pt;

    assign accept = start && !busy;
    assign we_pt  = accept && (count_reg < CW'(epml_pkg::MAX_POINTS));

    // Point memories: written at load, read by scan index during Prim and
    // at the picked point while draining.
    logic [IW-1:0] raddr;
    assign raddr = (state_reg == S_ROUND) ? scan_reg[IW-1:0] : pick_reg;

    epml_ram #(.WIDTH(32), .DEPTH(epml_pkg::MAX_POINTS)) u_x (
        .clk(clk), .we(we_pt), .waddr(count_reg[IW-1:0]), .wdata(point.coord_x),
        .raddr(raddr), .rdata(xr));
    epml_ram #(.WIDTH(32), .DEPTH(epml_pkg::MAX_POINTS)) u_y (
        .clk(clk), .we(we_pt), .waddr(count_reg[IW-1:0]), .wdata(point.coord_y),
        .raddr(raddr), .rdata(yr));

    // Stage after the read: index and issue flag follow the read latency.
    logic          rd_v_reg;
    logic [IW-1:0] rd_i_reg;
    logic          issue;
    assign issue = (state_reg == S_ROUND) && (scan_reg < count_reg)
                   && (round_reg < count_reg);

    // Difference and squares.
    logic          d_v_reg;
    logic [IW-1:0] d_i_reg;
    logic [32:0]   dx_reg, dy_reg;
    logic          q_v_reg;
    logic [IW-1:0] q_i_reg;
    logic [65:0]   s_reg;
    logic signed [32:0] ddx, ddy;
    assign ddx = 33'($signed(xr)) - 33'($signed(cx_reg));
    assign ddy = 33'($signed(yr)) - 33'($signed(cy_reg));

    // Index pipeline along the cells.
    logic [NC:0]        cv;
    logic [65:0]        crem [NC+1];
    logic [32:0]        croot [NC+1];
    logic [5:0]         cbit [NC+1];
    logic [IW-1:0]      cidx [NC+1];

    assign cv[0]    = q_v_reg;
    assign crem[0]  = s_reg;
    assign croot[0] = 33'd0;
    assign cbit[0]  = 6'd32;
    assign cidx[0]  = q_i_reg;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        epml_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .in_valid(cv[k]), .in_rem(crem[k]),
            .in_root(croot[k]), .in_bit(cbit[k]), .out_valid(cv[k+1]),
            .out_rem(crem[k+1]), .out_root(croot[k+1]), .out_bit(cbit[k+1]));
        always_ff @(posedge clk)
        begin
            cidx[k+1] <= cidx[k];
        end
    end

    // Scale by KQ as 33x16 and 33x17 partial products, then round.
    logic          m_v_reg, e_v_reg;
    logic [IW-1:0] m_i_reg, e_i_reg;
    logic [49:0]   plo_reg, phi_reg;
    logic [LW-1:0] e_reg;
    logic [66:0]   prod;
    assign prod = (67'(phi_reg) << 16) + 67'(plo_reg) + (67'd1 << 34);

    logic          pipe_busy;
    assign pipe_busy = rd_v_reg || d_v_reg || q_v_reg || (|cv) || m_v_reg || e_v_reg;

    // Best-link memory keeps the in-tree flag above the link length and is
    // read at the multiply stage's index, so its word meets the edge result.
    logic [IW-1:0] b_raddr;
    assign b_raddr = m_i_reg;
    logic          first_round;
    logic          joined;
    logic          pick_we;
    logic          bwe;
    logic [IW-1:0] bwa;
    logic [LW:0]   bwd;
    logic [LW-1:0] newbest;
    logic [LW-1:0] oldbest;
    assign first_round = (round_reg == CW'(1));
    // Nothing is stored for this set before its first round ends, and then
    // only point 0 is in the tree.
    assign joined  = first_round ? (e_i_reg == IW'(0)) : br[LW];
    assign oldbest = first_round ? epml_pkg::LEN_MAX : br[LW-1:0];
    assign newbest = (e_reg < oldbest) ? e_reg : oldbest;
    assign pick_we = (state_reg == S_DRAIN) && !pipe_busy && found_reg;
    assign bwe = pick_we || (e_v_reg && (first_round || !joined));
    assign bwa = pick_we ? pick_reg : e_i_reg;
    assign bwd = pick_we ? {1'b1, min_reg} : {joined, newbest};

    epml_ram #(.WIDTH(LW + 1), .DEPTH(epml_pkg::MAX_POINTS)) u_best (
        .clk(clk), .we(bwe), .waddr(bwa), .wdata(bwd),
        .raddr(b_raddr), .rdata(br));

    logic [LW:0] sum;
    assign sum = {1'b0, total_reg} + {1'b0, min_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg <= 1'b0;
            d_v_reg  <= 1'b0;
            q_v_reg  <= 1'b0;
            m_v_reg  <= 1'b0;
            e_v_reg  <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue;
            d_v_reg  <= rd_v_reg;
            q_v_reg  <= d_v_reg;
            m_v_reg  <= cv[NC];
            e_v_reg  <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_i_reg <= scan_reg[IW-1:0];
        d_i_reg  <= rd_i_reg;
        dx_reg   <= ddx[32] ? 33'(-ddx) : 33'(ddx);
        dy_reg   <= ddy[32] ? 33'(-ddy) : 33'(ddy);
        q_i_reg  <= d_i_reg;
        s_reg    <= 66'(dx_reg) * 66'(dx_reg) + 66'(dy_reg) * 66'(dy_reg);
        m_i_reg  <= cidx[NC];
        plo_reg  <= 50'(croot[NC]) * 50'(epml_pkg::KQ[15:0]);
        phi_reg  <= 50'(croot[NC]) * 50'(epml_pkg::KQ[32:16]);
        e_i_reg  <= m_i_reg;
        e_reg    <= LW'(prod >> 35);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            scan_reg     <= '0;
            round_reg    <= '0;
            total_reg    <= '0;
            sat_reg      <= 1'b0;
            min_reg      <= '0;
            pick_reg     <= '0;
            found_reg    <= 1'b0;
            result_valid <= 1'b0;
            result       <= '0;
            cx_reg       <= '0;
            cy_reg       <= '0;
        end
        else
        begin
            result_valid <= (state_reg == S_DONE);
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (we_pt && count_reg == '0)
                        begin
                            cx_reg <= point.coord_x;
                            cy_reg <= point.coord_y;
                        end
                        if (we_pt)
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        if (point.last_point)
                        begin
                            total_reg <= '0;
                            sat_reg   <= 1'b0;
                            round_reg <= CW'(1);
                            scan_reg  <= '0;
                            found_reg <= 1'b0;
                            // A set of one point has nothing to join.
                            state_reg <= (we_pt && count_reg == '0) ? S_DONE : S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    if (round_reg >= count_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        // The picked point's coordinates arrive in the first
                        // cycle of every later round.
                        if (scan_reg == '0 && round_reg > CW'(1))
                        begin
                            cx_reg <= xr;
                            cy_reg <= yr;
                        end
                        if (scan_reg < count_reg)
                        begin
                            scan_reg <= scan_reg + CW'(1);
                        end
                        else
                        begin
                            state_reg <= S_DRAIN;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (!pipe_busy)
                    begin
                        if (!found_reg)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if (sum[LW])
                            begin
                                total_reg <= epml_pkg::LEN_MAX;
                                sat_reg   <= 1'b1;
                            end
                            else
                            begin
                                total_reg <= sum[LW-1:0];
                            end
                            round_reg <= round_reg + CW'(1);
                            scan_reg  <= '0;
                            found_reg <= 1'b0;
                            state_reg <= S_ROUND;
                        end
                    end
                end
                S_DONE:
                begin
                    result.tree_length <= total_reg;
                    result.point_count <= 9'(count_reg);
                    result.saturated   <= sat_reg;
                    count_reg          <= '0;
                    state_reg          <= S_LOAD;
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
            // Track the minimum over the edges of this round, lowest index first.
            if (e_v_reg && !joined)
            begin
                if (!found_reg || newbest < min_reg
                    || (newbest == min_reg && e_i_reg < pick_reg))
                begin
                    min_reg   <= newbest;
                    pick_reg  <= e_i_reg;
                    found_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = (state_reg != S_LOAD);

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(epml_pkg::MAX_POINTS))
        else $error("point count past store depth");
endmodule

// File: hdl/epml_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module epml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/epml_sqrt_cell.sv
// One cell of the square root chain: decides one root bit per cycle.
// No dependencies.
module epml_sqrt_cell (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [65:0] in_rem,
    input  logic [32:0] in_root,
    input  logic [5:0]  in_bit,
    output logic        out_valid,
    output logic [65:0] out_rem,
    output logic [32:0] out_root,
    output logic [5:0]  out_bit
);
    logic [67:0] trial;
    logic [67:0] rem_ext;
    logic        take;

    // Restoring square root: subtract (root << (bit + 1)) + (1 << 2*bit) when it fits.
    always_comb
    begin
        trial   = ({35'd0, in_root} << (in_bit + 6'd1)) | (68'd1 << {in_bit, 1'b0});
        rem_ext = {2'b00, in_rem};
        take    = rem_ext >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_rem   <= take ? 66'(rem_ext - trial) : in_rem;
        out_root  <= take ? (in_root | (33'd1 << in_bit)) : in_root;
        out_bit   <= in_bit - 6'd1;
    end
endmodule

// File: tb/mst_length_checker.sv
`timescale 1ns / 1ps
// Checker for the Euclidean Prim spanning tree length core: watches the point
// and result transfers, predicts each tree length and compares. Uses epml_pkg.
module mst_length_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  epml_pkg::point_t  point,
    input  logic              result_valid,
    input  epml_pkg::result_t result,
    output int                fail_count,
    output int                pending
);
    logic [31:0]          pts_x [epml_pkg::MAX_POINTS];
    logic [31:0]          pts_y [epml_pkg::MAX_POINTS];
    int                   pts_loaded;
    epml_pkg::result_t    expected_trees [$];

    function automatic logic [32:0] abs_delta(logic [31:0] a, logic [31:0] b);
        logic signed [32:0] d;
        d = $signed({a[31], a}) - $signed({b[31], b});
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic [47:0] edge_metres(int i, int j);
        logic [67:0] dx, dy, sq, r, c, prod;
        dx = {35'b0, abs_delta(pts_x[i], pts_x[j])};
        dy = {35'b0, abs_delta(pts_y[i], pts_y[j])};
        sq = dx * dx + dy * dy;
        r = '0;
        for (int b = 32; b >= 0; b--)
        begin
            c = r | (68'd1 << b);
            if (c * c <= sq)
                r = c;
        end
        prod = r * {35'b0, epml_pkg::KQ} + (68'd1 << 34);
        return 48'(prod >> 35);
    endfunction

    function automatic epml_pkg::result_t predict_tree(int n);
        bit                joined [epml_pkg::MAX_POINTS];
        logic [47:0]       link [epml_pkg::MAX_POINTS];
        logic [47:0]       e, min_len;
        logic [48:0]       total;
        int                cur, pick;
        epml_pkg::result_t res;
        res.saturated = 1'b0;
        total = '0;
        cur = 0;
        for (int k = 0; k < n; k++)
        begin
            joined[k] = 1'b0;
            link[k] = epml_pkg::LEN_MAX;
        end
        joined[0] = 1'b1;
        link[0] = '0;
        for (int step = 1; step < n; step++)
        begin
            min_len = epml_pkg::LEN_MAX;
            pick = n;
            for (int k = 0; k < n; k++)
            begin
                if (!joined[k])
                begin
                    e = edge_metres(cur, k);
                    if (e < link[k])
                        link[k] = e;
                    // Strict compare keeps the lowest index on ties.
                    if (pick == n || link[k] < min_len)
                    begin
                        min_len = link[k];
                        pick = k;
                    end
                end
            end
            total = total + min_len;
            if (total > {1'b0, epml_pkg::LEN_MAX})
            begin
                total = {1'b0, epml_pkg::LEN_MAX};
                res.saturated = 1'b1;
            end
            joined[pick] = 1'b1;
            cur = pick;
        end
        res.tree_length = total[47:0];
        res.point_count = 9'(n);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        epml_pkg::result_t want;
        int                errs;
        errs = 0;
        if (!rst_n)
        begin
            pts_loaded = 0;
            fail_count <= 0;
            pending <= 0;
            expected_trees.delete();
        end
        else
        begin
            if (start && !busy)
            begin
                if (pts_loaded < epml_pkg::MAX_POINTS)
                begin
                    pts_x[pts_loaded] = point.coord_x;
                    pts_y[pts_loaded] = point.coord_y;
                    pts_loaded = pts_loaded + 1;
                end
                if (point.last_point)
                begin
                    expected_trees = {expected_trees, predict_tree(pts_loaded)};
                    pts_loaded = 0;
                end
            end
            if (result_valid)
            begin
                if (expected_trees.size() == 0)
                begin
                    $error("result transfer with no expected result");
                    errs = errs + 1;
                end
                else
                begin
                    want = expected_trees.pop_front();
                    if (result.tree_length !== want.tree_length)
                    begin
                        $error("tree_length expected %0d actual %0d",
                               want.tree_length, result.tree_length);
                        errs = errs + 1;
                    end
                    if (result.point_count !== want.point_count)
                    begin
                        $error("point_count expected %0d actual %0d",
                               want.point_count, result.point_count);
                        errs = errs + 1;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated expected %0d actual %0d",
                               want.saturated, result.saturated);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= expected_trees.size();
        end
    end
endmodule

// File: tb/euclidean_prim_mst_length_core_tb.sv
`timescale 1ns / 1ps
// Top of the testbench for the spanning tree length core: drives point sets
// and gives the verdict. Depends on epml_pkg, mst_length_checker and the core.
module euclidean_prim_mst_length_core_tb;
    localparam int IDLE_LIMIT = 400000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    epml_pkg::point_t  point;
    logic              result_valid;
    epml_pkg::result_t result;
    int                fail_count;
    int                pending;
    int                idle_pct;
    int                quiet_cycles;
    int                items_sent;
    logic [31:0]       prev_x, prev_y;

    euclidean_prim_mst_length_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .result_valid(result_valid), .result(result)
    );

    mst_length_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .point(point),
        .result_valid(result_valid), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on cycles with no transfer in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Busy is looked at before the edge so the transfer is counted once.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        point <= '{coord_x: x, coord_y: y, last_point: last};
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        items_sent++;
        prev_x = x;
        prev_y = y;
    endtask

    function automatic logic [31:0] pick_coord(logic [31:0] prev);
        unique case ($urandom_range(0, 4))
            0: return $urandom;
            1: return prev + 32'($signed($urandom_range(0, 2000)) - 1000);
            2: unique case ($urandom_range(0, 3))
                   0: return 32'h8000_0000;
                   1: return 32'h7fff_ffff;
                   2: return 32'h0;
                   default: return 32'hffff_ffff;
               endcase
            3: return prev;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    task automatic send_set(int n);
        for (int k = 0; k < n; k++)
            send_point(pick_coord(prev_x), pick_coord(prev_y), k == n - 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        point = '0;
        idle_pct = 0;
        quiet_cycles = 0;
        items_sent = 0;
        prev_x = '0;
        prev_y = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single point, extreme pair, duplicates that tie, mixed extremes.
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
        send_point(32'd0, 32'd0, 1'b0);
        send_point(32'd100, 32'd0, 1'b0);
        send_point(32'd0, 32'd100, 1'b0);
        send_point(32'd100, 32'd0, 1'b0);
        send_point(32'd0, 32'd0, 1'b1);
        send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
        send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_point(32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_point(32'h0000_0001, 32'hffff_ffff, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 18 : (phase == 1) ? 70 : 0;
            // A full store, and one that overflows so its last point drops.
            if (phase == 1)
                send_set(epml_pkg::MAX_POINTS);
            if (phase == 2)
                send_set(epml_pkg::MAX_POINTS + 5);
            while (items_sent < 600 * (phase + 1))
                send_set(($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12));
        end
        start <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
